/* rtl/ica_pkg.sv */
package ica_pkg;

    localparam int STEP_W  = 5;
    localparam int XY_W    = 36;
    localparam int Z_W     = 26;
    localparam int EST_W   = 24;
    localparam int G_W     = 28;
    localparam int FUSE_W  = 40;
    localparam int MA_W    = 28;
    localparam int MB_W    = 18;
    localparam int PROD_W  = MA_W + MB_W;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [EST_W-1:0] ANGLE_LIMIT = 24'sd4608000;
    localparam logic signed [G_W-1:0]   YAW_HALF    = 28'sd4608000;
    localparam logic signed [G_W-1:0]   YAW_PERIOD  = 28'sd9216000;
    localparam logic signed [17:0]      ATAN_LIMIT  = 18'sd9000;

    localparam logic [2:0] REG_ROLL_OFS  = 3'd0;
    localparam logic [2:0] REG_PITCH_OFS = 3'd1;
    localparam logic [2:0] REG_BIAS_X    = 3'd2;
    localparam logic [2:0] REG_BIAS_Y    = 3'd3;
    localparam logic [2:0] REG_BIAS_Z    = 3'd4;
    localparam logic [2:0] REG_SCALE     = 3'd5;
    localparam logic [2:0] REG_BLEND     = 3'd6;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] roll_out;
        logic signed [15:0] pitch_out;
        logic signed [15:0] yaw_out;
    } t_out_item;

    typedef struct packed {
        logic signed [14:0] roll_offset;
        logic signed [14:0] pitch_offset;
        logic signed [15:0] rate_bias_x;
        logic signed [15:0] rate_bias_y;
        logic signed [15:0] rate_bias_z;
        logic [15:0]        step_scale;
        logic [8:0]         blend_weight;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_CINIT, S_CORDIC, S_ANG, S_GYRO, S_FUSE, S_WRAP, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_AXX, MUL_AYY, MUL_AZZ, MUL_GX, MUL_GY, MUL_GZ,
        MUL_WR, MUL_AR, MUL_WP, MUL_AP
    } t_mul_op;

    typedef struct packed {
        logic              capture;
        t_mul_op           mul_op;
        logic              sqrt_step;
        logic              cordic_init;
        logic              cordic_step;
        logic              ang;
        logic              wrap;
        logic              load_out;
        logic [STEP_W-1:0] step;
    } t_cmd;

    // arctan(2^-i) in degrees, Q16
    function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] i);
        case (i)
            5'd0:    atan_q16 = 22'd2949120;
            5'd1:    atan_q16 = 22'd1740967;
            5'd2:    atan_q16 = 22'd919879;
            5'd3:    atan_q16 = 22'd466945;
            5'd4:    atan_q16 = 22'd234379;
            5'd5:    atan_q16 = 22'd117304;
            5'd6:    atan_q16 = 22'd58666;
            5'd7:    atan_q16 = 22'd29335;
            5'd8:    atan_q16 = 22'd14668;
            5'd9:    atan_q16 = 22'd7334;
            5'd10:   atan_q16 = 22'd3667;
            5'd11:   atan_q16 = 22'd1833;
            5'd12:   atan_q16 = 22'd917;
            5'd13:   atan_q16 = 22'd458;
            5'd14:   atan_q16 = 22'd229;
            5'd15:   atan_q16 = 22'd115;
            5'd16:   atan_q16 = 22'd57;
            5'd17:   atan_q16 = 22'd29;
            5'd18:   atan_q16 = 22'd14;
            5'd19:   atan_q16 = 22'd7;
            5'd20:   atan_q16 = 22'd4;
            5'd21:   atan_q16 = 22'd2;
            5'd22:   atan_q16 = 22'd1;
            default: atan_q16 = 22'd0;
        endcase
    endfunction

endpackage

/* rtl/ica_ctrl.sv */
module ica_ctrl
    import ica_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_busy,
    input  logic i_wrap_done,
    output logic o_idle,
    output t_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_SQ;
            S_SQ:     if (r_cnt == 5'd2) n_state = S_SQRT;
            S_SQRT:   if (r_cnt == 5'd15) n_state = S_CINIT;
            S_CINIT:  n_state = S_CORDIC;
            S_CORDIC: if (r_cnt == STEP_W'(CORDIC_STEPS - 1)) n_state = S_ANG;
            S_ANG:    n_state = S_GYRO;
            S_GYRO:   if (r_cnt == 5'd2) n_state = S_FUSE;
            S_FUSE:   if (r_cnt == 5'd3) n_state = S_WRAP;
            S_WRAP:   if (i_wrap_done) n_state = S_DONE;
            S_DONE:   if (!i_out_busy) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        n_cnt = (n_state != r_state) ? '0 : r_cnt + 5'd1;
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.mul_op = MUL_NONE;
        o_cmd.step   = r_cnt;
        o_idle       = (r_state == S_IDLE);
        case (r_state)
            S_IDLE:   o_cmd.capture = i_in_valid;
            S_SQ: begin
                case (r_cnt)
                    5'd0:    o_cmd.mul_op = MUL_AXX;
                    5'd1:    o_cmd.mul_op = MUL_AYY;
                    default: o_cmd.mul_op = MUL_AZZ;
                endcase
            end
            S_SQRT:   o_cmd.sqrt_step = 1'b1;
            S_CINIT:  o_cmd.cordic_init = 1'b1;
            S_CORDIC: o_cmd.cordic_step = 1'b1;
            S_ANG:    o_cmd.ang = 1'b1;
            S_GYRO: begin
                case (r_cnt)
                    5'd0:    o_cmd.mul_op = MUL_GX;
                    5'd1:    o_cmd.mul_op = MUL_GY;
                    default: o_cmd.mul_op = MUL_GZ;
                endcase
            end
            S_FUSE: begin
                case (r_cnt)
                    5'd0:    o_cmd.mul_op = MUL_WR;
                    5'd1:    o_cmd.mul_op = MUL_AR;
                    5'd2:    o_cmd.mul_op = MUL_WP;
                    default: o_cmd.mul_op = MUL_AP;
                endcase
            end
            S_WRAP:   o_cmd.wrap = 1'b1;
            S_DONE:   o_cmd.load_out = !i_out_busy;
            default:  o_cmd = '0;
        endcase
    end

endmodule

/* rtl/ica_dpath.sv */
module ica_dpath
    import ica_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_wrap_done,
    output t_out_item o_result
);

    t_in_item                  r_in;
    logic [31:0]               r_nr, r_np, r_root_r, r_root_p;
    logic signed [XY_W-1:0]    r_x_r, r_y_r, r_x_p, r_y_p;
    logic signed [Z_W-1:0]     r_z_r, r_z_p;
    logic signed [15:0]        r_acc_r, r_acc_p;
    logic signed [G_W-1:0]     r_g_r, r_g_p, r_g_y;
    logic signed [FUSE_W-1:0]  r_f_r, r_f_p;
    logic signed [EST_W-1:0]   r_est_r, r_est_p, r_est_y;

    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [G_W-1:0]     inc;
    logic [8:0]                w_eff, w_inv;
    logic signed [16:0]        num_r, num_p;

    assign w_eff = (i_cfg.blend_weight > 9'd256) ? 9'd256 : i_cfg.blend_weight;
    assign w_inv = 9'd256 - w_eff;
    assign num_r = 17'(r_in.accel_y);
    assign num_p = -17'(r_in.accel_x);

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_op)
            MUL_AXX: begin mul_a = MA_W'(r_in.accel_x); mul_b = MB_W'(r_in.accel_x); end
            MUL_AYY: begin mul_a = MA_W'(r_in.accel_y); mul_b = MB_W'(r_in.accel_y); end
            MUL_AZZ: begin mul_a = MA_W'(r_in.accel_z); mul_b = MB_W'(r_in.accel_z); end
            MUL_GX: begin
                mul_a = MA_W'(17'(r_in.rate_x) - 17'(i_cfg.rate_bias_x));
                mul_b = {2'b00, i_cfg.step_scale};
            end
            MUL_GY: begin
                mul_a = MA_W'(17'(r_in.rate_y) - 17'(i_cfg.rate_bias_y));
                mul_b = {2'b00, i_cfg.step_scale};
            end
            MUL_GZ: begin
                mul_a = MA_W'(17'(r_in.rate_z) - 17'(i_cfg.rate_bias_z));
                mul_b = {2'b00, i_cfg.step_scale};
            end
            MUL_WR:  begin mul_a = r_g_r; mul_b = {9'b0, w_eff}; end
            MUL_WP:  begin mul_a = r_g_p; mul_b = {9'b0, w_eff}; end
            MUL_AR: begin
                mul_a = MA_W'($signed({r_acc_r, 8'b0}));
                mul_b = {9'b0, w_inv};
            end
            MUL_AP: begin
                mul_a = MA_W'($signed({r_acc_p, 8'b0}));
                mul_b = {9'b0, w_inv};
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        prod = PROD_W'(mul_a) * PROD_W'(mul_b);
        inc  = G_W'(prod >>> 8);
    end

    // integer square root, two bits of radicand per step
    logic [31:0] sq_bit;
    logic [32:0] t_r, t_p;
    assign sq_bit = 32'd1 << {4'd15 - i_cmd.step[3:0], 1'b0};
    assign t_r    = {1'b0, r_root_r} + {1'b0, sq_bit};
    assign t_p    = {1'b0, r_root_p} + {1'b0, sq_bit};

    // cordic vectoring step
    logic signed [XY_W-1:0] xs_r, ys_r, xs_p, ys_p;
    logic signed [Z_W-1:0]  atn;
    assign xs_r = r_x_r >>> i_cmd.step;
    assign ys_r = r_y_r >>> i_cmd.step;
    assign xs_p = r_x_p >>> i_cmd.step;
    assign ys_p = r_y_p >>> i_cmd.step;
    assign atn  = Z_W'(atan_q16(i_cmd.step));

    // angle conversion to hundredths with clamp
    function automatic logic signed [15:0] to_hund(
        input logic signed [Z_W-1:0] z, input logic [31:0] root,
        input logic signed [16:0] num, input logic signed [14:0] ofs);
        logic signed [33:0] s;
        logic signed [17:0] r;
        s = 34'(z) * 34'sd100 + 34'sd32768;
        r = 18'(s >>> 16);
        if (root == 32'd0) begin
            r = (num > 0) ? ATAN_LIMIT : ((num < 0) ? -ATAN_LIMIT : 18'sd0);
        end else if (r > ATAN_LIMIT) begin
            r = ATAN_LIMIT;
        end else if (r < -ATAN_LIMIT) begin
            r = -ATAN_LIMIT;
        end
        to_hund = 16'(r - 18'(ofs));
    endfunction

    function automatic logic signed [EST_W-1:0] sat(input logic signed [FUSE_W-1:0] f);
        logic signed [FUSE_W-1:0] s;
        s = f >>> 8;
        if (s > FUSE_W'(ANGLE_LIMIT))       sat = ANGLE_LIMIT;
        else if (s < -FUSE_W'(ANGLE_LIMIT)) sat = -ANGLE_LIMIT;
        else                                 sat = EST_W'(s);
    endfunction

    assign o_wrap_done = (r_g_y >= 0) && (r_g_y < YAW_PERIOD);

    // architectural estimates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est_r <= '0;
            r_est_p <= '0;
            r_est_y <= '0;
        end else if (i_cmd.wrap) begin
            r_est_r <= sat(r_f_r);
            r_est_p <= sat(r_f_p);
            if (o_wrap_done) r_est_y <= EST_W'(r_g_y - YAW_HALF);
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_in <= i_item;

        case (i_cmd.mul_op)
            MUL_AXX: begin
                r_nr     <= 32'(prod);
                r_root_r <= '0;
                r_root_p <= '0;
            end
            MUL_AYY: r_np <= 32'(prod);
            MUL_AZZ: begin
                r_nr <= r_nr + 32'(prod);
                r_np <= r_np + 32'(prod);
            end
            MUL_GX:  r_g_r <= G_W'(r_est_r) + inc;
            MUL_GY:  r_g_p <= G_W'(r_est_p) + inc;
            MUL_GZ:  r_g_y <= G_W'(r_est_y) + inc + YAW_HALF;
            MUL_WR:  r_f_r <= FUSE_W'(prod);
            MUL_AR:  r_f_r <= r_f_r + FUSE_W'(prod);
            MUL_WP:  r_f_p <= FUSE_W'(prod);
            MUL_AP:  r_f_p <= r_f_p + FUSE_W'(prod);
            default: ;
        endcase

        if (i_cmd.sqrt_step) begin
            if ({1'b0, r_nr} >= t_r) begin
                r_nr     <= r_nr - 32'(t_r);
                r_root_r <= (r_root_r >> 1) + sq_bit;
            end else begin
                r_root_r <= r_root_r >> 1;
            end
            if ({1'b0, r_np} >= t_p) begin
                r_np     <= r_np - 32'(t_p);
                r_root_p <= (r_root_p >> 1) + sq_bit;
            end else begin
                r_root_p <= r_root_p >> 1;
            end
        end

        if (i_cmd.cordic_init) begin
            r_x_r <= XY_W'({r_root_r[15:0], 16'b0});
            r_x_p <= XY_W'({r_root_p[15:0], 16'b0});
            r_y_r <= XY_W'($signed({num_r, 16'b0}));
            r_y_p <= XY_W'($signed({num_p, 16'b0}));
            r_z_r <= '0;
            r_z_p <= '0;
        end

        if (i_cmd.cordic_step) begin
            if (r_y_r >= 0) begin
                r_x_r <= r_x_r + ys_r; r_y_r <= r_y_r - xs_r; r_z_r <= r_z_r + atn;
            end else begin
                r_x_r <= r_x_r - ys_r; r_y_r <= r_y_r + xs_r; r_z_r <= r_z_r - atn;
            end
            if (r_y_p >= 0) begin
                r_x_p <= r_x_p + ys_p; r_y_p <= r_y_p - xs_p; r_z_p <= r_z_p + atn;
            end else begin
                r_x_p <= r_x_p - ys_p; r_y_p <= r_y_p + xs_p; r_z_p <= r_z_p - atn;
            end
        end

        if (i_cmd.ang) begin
            r_acc_r <= to_hund(r_z_r, r_root_r, num_r, i_cfg.roll_offset);
            r_acc_p <= to_hund(r_z_p, r_root_p, num_p, i_cfg.pitch_offset);
        end

        // fold yaw back into one turn, one period per cycle
        if (i_cmd.wrap && !o_wrap_done) begin
            if (r_g_y < 0) r_g_y <= r_g_y + YAW_PERIOD;
            else           r_g_y <= r_g_y - YAW_PERIOD;
        end
    end

    // round half up to hundredths
    logic signed [EST_W:0] rnd_r, rnd_p, rnd_y;
    assign rnd_r = (EST_W+1)'(r_est_r) + 25'sd128;
    assign rnd_p = (EST_W+1)'(r_est_p) + 25'sd128;
    assign rnd_y = (EST_W+1)'(r_est_y) + 25'sd128;

    assign o_result.roll_out  = rnd_r[23:8];
    assign o_result.pitch_out = rnd_p[23:8];
    assign o_result.yaw_out   = rnd_y[23:8];

endmodule

/* rtl/imu_complementary_attitude_core.sv */
// Complementary attitude filter for a six-axis IMU. Each input transfer is one
// raw sample (accel x/y/z, rate x/y/z, signed 16-bit); each produces exactly one
// output transfer with fused roll, fused pitch and gyro-only yaw in hundredths of
// a degree (roll/pitch saturate at +-180 deg, yaw wraps). Samples are handled one
// at a time: an item passes the squares, the 16-step square root, the CORDIC
// arctangent loop, the gyro and fusion steps and a yaw wrap that repeats until
// yaw lies in one turn; the next sample stalls until the block is idle. The
// result sits in an output register, so a new sample is taken while the previous
// result still waits. Write configuration only while the block is idle.
module imu_complementary_attitude_core
    import ica_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // sample channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    // result channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_cmd      cmd;
    t_out_item result;
    logic      idle, wrap_done, out_busy;
    logic      r_out_valid;
    t_out_item r_out_data;

    // configuration registers; unknown indexes drop silently
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.roll_offset  <= '0;
            r_cfg.pitch_offset <= '0;
            r_cfg.rate_bias_x  <= '0;
            r_cfg.rate_bias_y  <= '0;
            r_cfg.rate_bias_z  <= '0;
            r_cfg.step_scale   <= 16'd500;
            r_cfg.blend_weight <= 9'd246;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROLL_OFS:  r_cfg.roll_offset  <= i_cfg_data[14:0];
                REG_PITCH_OFS: r_cfg.pitch_offset <= i_cfg_data[14:0];
                REG_BIAS_X:    r_cfg.rate_bias_x  <= i_cfg_data;
                REG_BIAS_Y:    r_cfg.rate_bias_y  <= i_cfg_data;
                REG_BIAS_Z:    r_cfg.rate_bias_z  <= i_cfg_data;
                REG_SCALE:     r_cfg.step_scale   <= i_cfg_data;
                REG_BLEND:     r_cfg.blend_weight <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // output slot is blocked only when it holds a result that is not being taken
    assign out_busy   = r_out_valid && i_out_stall;
    assign o_in_stall = !idle;

    ica_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (out_busy),
        .i_wrap_done(wrap_done),
        .o_idle     (idle),
        .o_cmd      (cmd)
    );

    ica_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_in_data),
        .i_cfg      (r_cfg),
        .o_wrap_done(wrap_done),
        .o_result   (result)
    );

    // output register: load a finished result, drop valid once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.load_out) r_out_data <= result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
